>>> sv/tod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

  localparam int FIELD_W   = 17;
  localparam int MS_W      = 10;
  localparam int CONS_W    = 8;
  localparam int NS_W      = 59;
  localparam int CHAR_W    = 8;

  localparam logic [FIELD_W-1:0] FIELD_MAX = FIELD_W'(99999);

  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int MS_PER_SEC   = 1000;
  // 1e6 ns per ms, applied as two steps of 1000
  localparam int NS_STEP      = 1000;

  localparam int DEF_MAX_CHARS = 255;

  typedef struct packed {
    logic               err;
    logic [FIELD_W-1:0] hours;
    logic [FIELD_W-1:0] minutes;
    logic [FIELD_W-1:0] seconds;
    logic [MS_W-1:0]    millis;
    logic [CONS_W-1:0]  consumed;
  } job_t;

endpackage

`default_nettype wire

>>> sv/tod_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tod_front
  import tod_pkg::*;
#(
  parameter int MAX_CHARS = DEF_MAX_CHARS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              char_valid_i,
  input  wire logic [CHAR_W-1:0] char_i,
  output logic                   job_push_o,
  output job_t                   job_o
);

  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam int EW = (CW > CONS_W) ? CW : CONS_W;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_HASH  = "#";
  localparam logic [CHAR_W-1:0] CH_COLON = ":";
  localparam logic [CHAR_W-1:0] CH_DOT   = ".";
  localparam logic [CHAR_W-1:0] CH_ZERO  = "0";
  localparam logic [CHAR_W-1:0] CH_NINE  = "9";
  localparam logic [CHAR_W-1:0] CH_A_UP  = "A";
  localparam logic [CHAR_W-1:0] CH_Z_UP  = "Z";
  localparam logic [CHAR_W-1:0] CH_T_LO  = "t";
  localparam logic [CHAR_W-1:0] CH_O_LO  = "o";
  localparam logic [CHAR_W-1:0] CH_D_LO  = "d";
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'd32;

  localparam logic [2:0] CAND_TOD   = 3'b001;
  localparam logic [2:0] CAND_LOWER = 3'b010;
  localparam logic [2:0] CAND_UPPER = 3'b100;
  localparam logic [2:0] CAND_ALL   = 3'b111;

  localparam logic [3:0] POS_TOD_END  = 4'd3;
  localparam logic [3:0] POS_WORD_END = 4'd11;

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_BODY,
    PH_HOURS,
    PH_MINUTES,
    PH_SECONDS,
    PH_FRACTION,
    PH_SKIP
  } phase_e;

  // letter of the long prefix word at a position, in either case
  function automatic logic [CHAR_W-1:0] word_char(input logic upper, input logic [3:0] idx);
    logic [CHAR_W-1:0] ch;
    begin
      case (idx)
        4'd0:    ch = "t";
        4'd1:    ch = "i";
        4'd2:    ch = "m";
        4'd3:    ch = "e";
        4'd4:    ch = "_";
        4'd5:    ch = "o";
        4'd6:    ch = "f";
        4'd7:    ch = "_";
        4'd8:    ch = "d";
        4'd9:    ch = "a";
        4'd10:   ch = "y";
        default: ch = CH_NUL;
      endcase
      if (upper && ch != "_" && ch != CH_NUL) begin
        ch = ch - CASE_OFS;
      end
      return ch;
    end
  endfunction

  function automatic logic [FIELD_W-1:0] accumulate(input logic [FIELD_W-1:0] v,
                                                    input logic [3:0] d);
    logic [FIELD_W+2:0] t;
    begin
      t = (FIELD_W+3)'(v) * (FIELD_W+3)'(10) + (FIELD_W+3)'(d);
      return (t > (FIELD_W+3)'(FIELD_MAX)) ? FIELD_MAX : t[FIELD_W-1:0];
    end
  endfunction

  phase_e             phase_q, phase_d;
  logic [3:0]         pos_q, pos_d;
  logic [2:0]         cand_q, cand_d;
  logic [FIELD_W-1:0] hour_q, hour_d, min_q, min_d, sec_q, sec_d;
  logic [MS_W-1:0]    ms_q, ms_d;
  logic [1:0]         fd_q, fd_d;
  logic [CW-1:0]      cnt_q, cnt_d;

  logic               starting;
  logic [FIELD_W-1:0] eh, em, es;
  logic [MS_W-1:0]    ems;
  logic [1:0]         efd;
  logic [CW-1:0]      ecnt, cnt_inc;
  logic [EW-1:0]      cnt_ext;
  logic [CHAR_W-1:0]  lc;
  logic               is_digit;
  logic [3:0]         dval;
  logic               emit, err, do_hours, done;
  logic [2:0]         keep;
  logic [MS_W-1:0]    ms_pad;

  always_comb begin
    starting = (phase_q == PH_START);
    eh   = starting ? '0 : hour_q;
    em   = starting ? '0 : min_q;
    es   = starting ? '0 : sec_q;
    ems  = starting ? '0 : ms_q;
    efd  = starting ? '0 : fd_q;
    ecnt = starting ? '0 : cnt_q;

    lc       = (char_i inside {[CH_A_UP:CH_Z_UP]}) ? char_i + CASE_OFS : char_i;
    is_digit = (char_i inside {[CH_ZERO:CH_NINE]});
    dval     = 4'(char_i - CH_ZERO);
    cnt_inc  = (ecnt < CW'(MAX_CHARS)) ? CW'(ecnt + 1'b1) : ecnt;

    phase_d = phase_q;
    pos_d   = starting ? '0 : pos_q;
    cand_d  = starting ? CAND_ALL : cand_q;
    hour_d  = eh;
    min_d   = em;
    sec_d   = es;
    ms_d    = ems;
    fd_d    = efd;
    cnt_d   = ecnt;

    emit     = 1'b0;
    err      = 1'b0;
    do_hours = 1'b0;
    done     = 1'b0;
    keep     = '0;

    case (phase_q)
      PH_START, PH_BODY: begin
        if (starting && lc == CH_T_LO) begin
          cand_d  = CAND_TOD | ((char_i == CH_T_LO) ? CAND_LOWER : CAND_UPPER);
          pos_d   = 4'd1;
          cnt_d   = cnt_inc;
          phase_d = PH_PREFIX;
        end else if (char_i == CH_NUL) begin
          emit = 1'b1;
          err  = 1'b1;
        end else begin
          phase_d  = PH_HOURS;
          do_hours = 1'b1;
        end
      end
      PH_PREFIX: begin
        if ((cand_q & CAND_TOD) != '0) begin
          if (pos_q == POS_TOD_END && char_i == CH_HASH) begin
            done = 1'b1;
          end
          if ((pos_q == 4'd1 && lc == CH_O_LO) || (pos_q == 4'd2 && lc == CH_D_LO)) begin
            keep = keep | CAND_TOD;
          end
        end
        if ((cand_q & (CAND_LOWER | CAND_UPPER)) != '0 && pos_q inside {[4'd1:POS_WORD_END]}) begin
          if (pos_q == POS_WORD_END) begin
            if (char_i == CH_HASH) begin
              done = 1'b1;
            end
          end else begin
            if ((cand_q & CAND_LOWER) != '0 && char_i == word_char(1'b0, pos_q)) begin
              keep = keep | CAND_LOWER;
            end
            if ((cand_q & CAND_UPPER) != '0 && char_i == word_char(1'b1, pos_q)) begin
              keep = keep | CAND_UPPER;
            end
          end
        end
        if (done) begin
          cnt_d   = cnt_inc;
          phase_d = PH_BODY;
        end else if (keep == '0) begin
          emit = 1'b1;
          err  = 1'b1;
        end else begin
          cand_d = keep;
          pos_d  = pos_q + 4'd1;
          cnt_d  = cnt_inc;
        end
      end
      PH_HOURS: begin
        do_hours = 1'b1;
      end
      PH_MINUTES: begin
        if (is_digit) begin
          min_d = accumulate(em, dval);
          cnt_d = cnt_inc;
        end else if (char_i == CH_COLON) begin
          cnt_d   = cnt_inc;
          phase_d = PH_SECONDS;
        end else begin
          emit = 1'b1;
        end
      end
      PH_SECONDS: begin
        if (is_digit) begin
          sec_d = accumulate(es, dval);
          cnt_d = cnt_inc;
        end else if (char_i == CH_DOT) begin
          cnt_d   = cnt_inc;
          phase_d = PH_FRACTION;
        end else begin
          emit = 1'b1;
        end
      end
      PH_FRACTION: begin
        if (is_digit) begin
          if (efd != 2'd3) begin
            ms_d = MS_W'(ems * MS_W'(10) + MS_W'(dval));
            fd_d = efd + 2'd1;
          end
          cnt_d = cnt_inc;
        end else begin
          emit = 1'b1;
        end
      end
      PH_SKIP: begin
        if (char_i == CH_NUL) begin
          phase_d = PH_START;
        end
      end
      default: begin
        phase_d = PH_START;
      end
    endcase

    if (do_hours) begin
      if (is_digit) begin
        hour_d = accumulate(eh, dval);
        cnt_d  = cnt_inc;
      end else if (char_i == CH_COLON) begin
        cnt_d   = cnt_inc;
        phase_d = PH_MINUTES;
      end else begin
        emit = 1'b1;
        err  = (char_i != CH_NUL);
      end
    end

    if (emit) begin
      phase_d = (char_i == CH_NUL) ? PH_START : PH_SKIP;
    end

    // pad the fraction out to milliseconds
    case (efd)
      2'd1:    ms_pad = MS_W'(ems * MS_W'(100));
      2'd2:    ms_pad = MS_W'(ems * MS_W'(10));
      2'd3:    ms_pad = ems;
      default: ms_pad = '0;
    endcase

    cnt_ext = EW'(ecnt);

    job_push_o     = char_valid_i && emit;
    job_o.err      = err;
    job_o.hours    = eh;
    job_o.minutes  = em;
    job_o.seconds  = es;
    job_o.millis   = ms_pad;
    job_o.consumed = (cnt_ext > EW'(8'hFF)) ? 8'hFF : cnt_ext[CONS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      pos_q   <= '0;
      cand_q  <= CAND_ALL;
      hour_q  <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      ms_q    <= '0;
      fd_q    <= '0;
      cnt_q   <= '0;
    end else if (char_valid_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cand_q  <= cand_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      ms_q    <= ms_d;
      fd_q    <= fd_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/tod_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tod_queue
  import tod_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o
);

  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/tod_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tod_back
  import tod_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  input  job_t                   job_i,
  output logic                   job_pop_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic                   status_o,
  output logic [NS_W-1:0]        time_ns_o,
  output logic [CONS_W-1:0]      consumed_o
);

  localparam int SEC_W  = 29;  // h*3600 + m*60 + s
  localparam int PART_W = 24;  // m*60 + s
  localparam int MS_ACC = 39;  // total milliseconds
  localparam int US_ACC = 49;  // total microseconds

  typedef enum logic [2:0] {
    S_IDLE,
    S_HM,
    S_SUM,
    S_MS,
    S_US,
    S_NS,
    S_OUT
  } state_e;

  state_e            state_q;
  job_t              job_q;
  logic [NS_W-1:0]   acc_q;
  logic [PART_W-1:0] part_q;
  logic              out_valid_q;

  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;
  assign empty_o   = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= '0;
      acc_q       <= '0;
      part_q      <= '0;
      out_valid_q <= 1'b0;
      status_o    <= 1'b0;
      time_ns_o   <= '0;
      consumed_o  <= '0;
    end else begin
      // in S_OUT the slot is refilled or kept below
      if (pop_i && out_valid_q && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            state_q <= S_HM;
          end
        end
        S_HM: begin
          acc_q   <= NS_W'(SEC_W'(job_q.hours) * SEC_W'(SEC_PER_HOUR));
          part_q  <= PART_W'(PART_W'(job_q.minutes) * PART_W'(SEC_PER_MIN)
                             + PART_W'(job_q.seconds));
          state_q <= S_SUM;
        end
        S_SUM: begin
          acc_q   <= NS_W'(acc_q[SEC_W-1:0] + SEC_W'(part_q));
          state_q <= S_MS;
        end
        S_MS: begin
          acc_q   <= NS_W'(MS_ACC'(acc_q[SEC_W-1:0]) * MS_ACC'(MS_PER_SEC)
                           + MS_ACC'(job_q.millis));
          state_q <= S_US;
        end
        S_US: begin
          acc_q   <= NS_W'(US_ACC'(acc_q[MS_ACC-1:0]) * US_ACC'(NS_STEP));
          state_q <= S_NS;
        end
        S_NS: begin
          acc_q   <= NS_W'(acc_q[US_ACC-1:0]) * NS_W'(NS_STEP);
          state_q <= S_OUT;
        end
        S_OUT: begin
          // wait for the result slot to free up
          if (!out_valid_q || pop_i) begin
            out_valid_q <= 1'b1;
            status_o    <= job_q.err;
            time_ns_o   <= job_q.err ? '0 : acc_q;
            consumed_o  <= job_q.err ? '0 : job_q.consumed;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/time_of_day_literal_parser.sv
// Channel  | Handshake     | Beat contents
// ---------+---------------+-------------------------------------
// input    | push / full   | char_code_i
// result   | empty / pop   | status_o, time_ns_o, consumed_o
//
// One character per cycle while full is low; the parser front takes each beat in a
// single cycle. A finished literal goes into a two-entry queue, and the converter
// behind it takes each result through load, five constant-multiply and add steps
// and hand-off. full rises only when both queue entries are taken. Reset is
// asynchronous; after it the parser waits for the start of a literal.
`timescale 1ns / 1ps
`default_nettype none

module time_of_day_literal_parser
  import tod_pkg::*;
#(
  parameter int MAX_CHARS = DEF_MAX_CHARS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CHAR_W-1:0] char_code_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   status_o,
  output logic [NS_W-1:0]        time_ns_o,
  output logic [CONS_W-1:0]      consumed_o
);

  logic accept;
  logic job_push;
  job_t job_in;
  logic q_full;
  logic q_empty;
  job_t job_out;
  logic job_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  tod_front #(
    .MAX_CHARS(MAX_CHARS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_valid_i(accept),
    .char_i      (char_code_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  tod_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (q_full),
    .pop_i  (job_pop),
    .data_o (job_out),
    .empty_o(q_empty)
  );

  tod_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!q_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .status_o   (status_o),
    .time_ns_o  (time_ns_o),
    .consumed_o (consumed_o)
  );

endmodule

`default_nettype wire
